>>> hdl/kba_pkg.sv
`default_nettype none
package kba_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_REALLOC = 3'd1,
    OP_FREE    = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_COMPACT = 3'd4,
    OP_LIST    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_PRESENT = 3'd1,
    STS_MISSING = 3'd2,
    STS_NOSPACE = 3'd3,
    STS_FULL    = 3'd4,
    STS_DIRTY   = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_APPLY  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  localparam int ID_W  = 32;
  localparam int LEN_W = 17;
  localparam int OFF_W = 16;

endpackage
`default_nettype wire

>>> hdl/kba_cell.sv
`default_nettype none
// One table slot: {key, offset, count, dirty, valid}; valid and dirty reset low.
module kba_cell
  import kba_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         shift,
  input  wire logic [W-1:0] d_in,
  output logic      [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[1:0] <= 2'b00;
    end else if (shift) begin
      q_r[1:0] <= d_in[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r[W-1:2] <= d_in[W-1:2];
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

>>> hdl/keyed_bump_allocator.sv
// Keyed bump allocator: a table of keyed extents in a vertex buffer.
// Input channel in_*: one command item per handshake (op, entry_id, length).
// Output channel out_*: one or more result items per command, out_tlast on the
// final one. Compact and list-dirty give one item per reported entry.
// The table is a ring of TABLE_ENTRIES cells that, during a command, rotates
// one slot per cycle unless a receiver stall halts it, past a head cell where
// all matching, placement and renumbering happens. Each command makes one full
// rotation to search, a decision step, and, when it changes the table or
// lists entries, a second rotation.
// A new command is accepted only once the previous one has left its last
// result in the output register; that register lets the next command start
// while the result waits.
// When the receiver stalls, the second rotation halts on the entry whose
// result cannot be handed over, and resumes when out_tready returns.
// Reset (rst_n low, synchronous) empties the table and clears edge, used and
// dead totals; no clearing pass is needed.
`default_nettype none
module keyed_bump_allocator
  import kba_pkg::*;
#(
  parameter int TABLE_ENTRIES   = 64,
  parameter int BUFFER_VERTICES = 65536,
  parameter int KEY_BITS        = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,   // op[2:0], entry_id[34:3], length[51:35]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [103:0] out_tdata,  // status[2:0], result_id[34:3], offset[50:35],
                                        // count[67:51], used_total[84:68],
                                        // dead_total[101:85]
  output logic              out_tlast
);

  localparam int N   = TABLE_ENTRIES;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int KW  = KEY_BITS;
  localparam int VW  = $clog2(BUFFER_VERTICES + 1);
  localparam int OW  = $clog2(BUFFER_VERTICES);
  localparam int FW  = ((VW > LEN_W) ? VW : LEN_W) + 1;
  localparam int OXW = (OW > OFF_W) ? OW : OFF_W;
  localparam int CW  = KW + OW + VW + 2;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  function automatic logic [LEN_W-1:0] to_len(input logic [VW-1:0] v);
    logic [FW-1:0] t;
    t = FW'(v);
    return t[LEN_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] to_off(input logic [OW-1:0] v);
    logic [OXW-1:0] t;
    t = OXW'(v);
    return t[OFF_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] to_id(input logic [KW-1:0] v);
    logic [KW+ID_W-1:0] t;
    t = {{ID_W{1'b0}}, v};
    return t[ID_W-1:0];
  endfunction

  function automatic logic [CW-1:0] mk_cell(input logic [KW-1:0] k, input logic [OW-1:0] o,
                                             input logic [VW-1:0] c, input logic d,
                                             input logic v);
    return {k, o, c, d, v};
  endfunction

  // ring of cells
  logic [CW-1:0] q [N];
  logic [CW-1:0] ring_back;
  logic          shift;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_ring
      kba_cell #(.W(CW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d_in  ((g == N - 1) ? ring_back : q[(g + 1) % N]),
        .q     (q[g])
      );
    end
  endgenerate

  logic [KW-1:0] h_key;
  logic [OW-1:0] h_off;
  logic [VW-1:0] h_cnt;
  logic          h_dirty, h_valid;
  assign h_key   = q[0][CW-1 -: KW];
  assign h_off   = q[0][VW+2 +: OW];
  assign h_cnt   = q[0][2 +: VW];
  assign h_dirty = q[0][1];
  assign h_valid = q[0][0];

  // control and scan registers
  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  op_e           op_r, op_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [VW-1:0] edge_r, edge_nxt, used_r, used_nxt, dead_r, dead_nxt;
  logic          fm_r, fm_nxt, ff_r, ff_nxt, anyd_r, anyd_nxt, hasv_r, hasv_nxt;
  logic [IW-1:0] mi_r, mi_nxt, fi_r, fi_nxt, lv_r, lv_nxt, ld_r, ld_nxt, tgt_r, tgt_nxt;
  logic [OW-1:0] mo_r, mo_nxt;
  logic [VW-1:0] mc_r, mc_nxt, sum_r, sum_nxt, pos_r, pos_nxt;
  logic          wr_r, wr_nxt;
  logic [CW-1:0] wcell_r, wcell_nxt;
  status_e       pst_r, pst_nxt;
  logic [KW-1:0] pid_r, pid_nxt;
  logic [OW-1:0] poff_r, poff_nxt;
  logic [VW-1:0] pcnt_r, pcnt_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [103:0]  out_data_r, out_data_nxt;

  logic [KW+ID_W-1:0] id_ext;
  logic [FW-1:0]      fit_sum;
  logic               fits;
  logic [VW-1:0]      used_drop;
  logic               is_cmp, emit_here, stall, last_here;

  assign id_ext    = {{KW{1'b0}}, in_tdata[34:3]};
  assign fit_sum   = FW'(edge_r) + FW'(len_r);
  assign fits      = (len_r != '0) && (fit_sum <= FW'(BUFFER_VERTICES));
  assign used_drop = (used_r >= mc_r) ? used_r - mc_r : '0;
  assign is_cmp    = (op_r == OP_COMPACT);
  assign emit_here = (state_r == S_APPLY) && h_valid && (is_cmp || h_dirty) &&
                     (is_cmp || op_r == OP_LIST);
  assign last_here = is_cmp ? (idx_r == lv_r) : (idx_r == ld_r);
  assign stall     = emit_here && out_valid_r && !out_tready;
  assign shift     = (state_r == S_SCAN) || ((state_r == S_APPLY) && !stall);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    ring_back = q[0];
    if (state_r == S_APPLY) begin
      if (op_r == OP_COMPACT) begin
        if (h_valid) begin
          ring_back = mk_cell(h_key, OW'(pos_r), h_cnt, h_dirty, h_valid);
        end
      end else if (op_r == OP_LIST) begin
        ring_back = mk_cell(h_key, h_off, h_cnt, 1'b0, h_valid);
      end else if (wr_r && idx_r == tgt_r) begin
        ring_back = wcell_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;   idx_nxt = idx_r;   op_nxt = op_r;   key_nxt = key_r;
    len_nxt = len_r;       edge_nxt = edge_r; used_nxt = used_r; dead_nxt = dead_r;
    fm_nxt = fm_r;   ff_nxt = ff_r;   anyd_nxt = anyd_r; hasv_nxt = hasv_r;
    mi_nxt = mi_r;   fi_nxt = fi_r;   lv_nxt = lv_r;     ld_nxt = ld_r;  tgt_nxt = tgt_r;
    mo_nxt = mo_r;   mc_nxt = mc_r;   sum_nxt = sum_r;   pos_nxt = pos_r;
    wr_nxt = wr_r;   wcell_nxt = wcell_r;
    pst_nxt = pst_r; pid_nxt = pid_r; poff_nxt = poff_r; pcnt_nxt = pcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;

    if (shift) begin
      idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = op_e'(in_tdata[2:0]);
          key_nxt  = id_ext[KW-1:0];
          len_nxt  = in_tdata[51:35];
          fm_nxt = 1'b0; ff_nxt = 1'b0; anyd_nxt = 1'b0; hasv_nxt = 1'b0;
          sum_nxt = '0;
          wr_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (h_valid && h_key == key_r && !fm_r) begin
          fm_nxt = 1'b1; mi_nxt = idx_r; mo_nxt = h_off; mc_nxt = h_cnt;
        end
        if (!h_valid && !ff_r) begin
          ff_nxt = 1'b1; fi_nxt = idx_r;
        end
        if (h_valid) begin
          hasv_nxt = 1'b1; lv_nxt = idx_r; sum_nxt = sum_r + h_cnt;
          if (h_dirty) begin
            anyd_nxt = 1'b1; ld_nxt = idx_r;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        pst_nxt = STS_OK; pid_nxt = key_r; poff_nxt = '0; pcnt_nxt = '0;
        pos_nxt = '0;
        state_nxt = S_EMIT;
        priority case (op_r)
          OP_ALLOC: begin
            if (fm_r) begin
              pst_nxt = STS_PRESENT;
            end else if (!fits) begin
              pst_nxt = STS_NOSPACE;
            end else if (!ff_r) begin
              pst_nxt = STS_FULL;
            end else begin
              wr_nxt = 1'b1; tgt_nxt = fi_r;
              wcell_nxt = mk_cell(key_r, OW'(edge_r), VW'(len_r), 1'b1, 1'b1);
              edge_nxt = edge_r + VW'(len_r); used_nxt = used_r + VW'(len_r);
              poff_nxt = OW'(edge_r); pcnt_nxt = VW'(len_r);
              state_nxt = S_APPLY;
            end
          end
          OP_REALLOC: begin
            if (!fm_r) begin
              pst_nxt = STS_MISSING;
            end else begin
              wr_nxt = 1'b1; tgt_nxt = mi_r;
              dead_nxt = dead_r + mc_r;
              state_nxt = S_APPLY;
              if (fits) begin
                wcell_nxt = mk_cell(key_r, OW'(edge_r), VW'(len_r), 1'b1, 1'b1);
                edge_nxt = edge_r + VW'(len_r); used_nxt = used_drop + VW'(len_r);
                poff_nxt = OW'(edge_r); pcnt_nxt = VW'(len_r);
              end else begin
                wcell_nxt = mk_cell(key_r, mo_r, mc_r, 1'b0, 1'b0);
                used_nxt = used_drop;
                pst_nxt = STS_NOSPACE; pcnt_nxt = mc_r;
              end
            end
          end
          OP_FREE: begin
            if (!fm_r) begin
              pst_nxt = STS_MISSING;
            end else begin
              wr_nxt = 1'b1; tgt_nxt = mi_r;
              wcell_nxt = mk_cell(key_r, mo_r, mc_r, 1'b0, 1'b0);
              dead_nxt = dead_r + mc_r; used_nxt = used_drop;
              poff_nxt = mo_r; pcnt_nxt = mc_r;
              state_nxt = S_APPLY;
            end
          end
          OP_LOOKUP: begin
            if (!fm_r) begin
              pst_nxt = STS_MISSING;
            end else begin
              poff_nxt = mo_r; pcnt_nxt = mc_r;
            end
          end
          OP_COMPACT: begin
            pid_nxt = '0;
            if (anyd_r) begin
              pst_nxt = STS_DIRTY;
            end else begin
              edge_nxt = sum_r; used_nxt = sum_r; dead_nxt = '0;
              if (hasv_r) begin
                state_nxt = S_APPLY;
              end
            end
          end
          OP_LIST: begin
            pid_nxt = '0;
            state_nxt = S_APPLY;
          end
          default: begin
            pid_nxt = '0;
          end
        endcase
      end
      S_APPLY: begin
        if (emit_here && !stall) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_here;
          out_data_nxt  = {2'b00, to_len(dead_r), to_len(used_r), to_len(h_cnt),
                           to_off(is_cmp ? OW'(pos_r) : h_off), to_id(h_key), STS_OK};
          if (is_cmp) begin
            pos_nxt = pos_r + h_cnt;
          end
        end
        if (shift && idx_r == LAST_IDX) begin
          if (op_r == OP_COMPACT || (op_r == OP_LIST && anyd_r)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_data_nxt  = {2'b00, to_len(dead_r), to_len(used_r), to_len(pcnt_r),
                           to_off(poff_r), to_id(pid_r), pst_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      edge_r      <= '0;
      used_r      <= '0;
      dead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      edge_r      <= edge_nxt;
      used_r      <= used_nxt;
      dead_r      <= dead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;   key_r <= key_nxt;   len_r <= len_nxt;
    fm_r <= fm_nxt;   ff_r <= ff_nxt;     anyd_r <= anyd_nxt; hasv_r <= hasv_nxt;
    mi_r <= mi_nxt;   fi_r <= fi_nxt;     lv_r <= lv_nxt;     ld_r <= ld_nxt;
    tgt_r <= tgt_nxt; mo_r <= mo_nxt;     mc_r <= mc_nxt;     sum_r <= sum_nxt;
    pos_r <= pos_nxt; wr_r <= wr_nxt;     wcell_r <= wcell_nxt;
    pst_r <= pst_nxt; pid_r <= pid_nxt;   poff_r <= poff_nxt; pcnt_r <= pcnt_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ring must be back in slot order whenever a new command can enter
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (idx_r == '0))
    else $error("ring not aligned at idle");

  // live plus dead space always accounts for everything below the edge
  a_space: assert property (@(posedge clk) disable iff (!rst_n)
    ((FW'(used_r) + FW'(dead_r)) == FW'(edge_r)))
    else $error("used + dead differs from edge");

  a_dirty_live: assert property (@(posedge clk) disable iff (!rst_n)
    h_dirty |-> h_valid)
    else $error("dirty mark on a free slot");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import kba_pkg::*;

  localparam int SLOTS = 64;
  localparam int CAPACITY = 65536;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [16:0] length;
    logic [31:0] entry_id;
    logic [2:0]  op;
  } cmd_t;

  typedef struct packed {
    logic [16:0] dead_total;
    logic [16:0] used_total;
    logic [16:0] count;
    logic [15:0] offset;
    logic [31:0] result_id;
    logic [2:0]  status;
    logic        last;
  } reply_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [55:0] in_tdata;
  logic [103:0] out_tdata;

  keyed_bump_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // allocator shadow state
  logic [31:0] tbl_key [SLOTS];
  logic        tbl_live [SLOTS];
  logic [15:0] tbl_off [SLOTS];
  logic [16:0] tbl_cnt [SLOTS];
  logic        tbl_dirty [SLOTS];
  int unsigned bump_edge, live_sum, dead_sum;

  cmd_t   cmd_queue[$];
  reply_t replies_due[$];
  int     errors = 0;
  bit     quiet_mode = 0;
  bit     hold_send = 0;
  bit     in_taken = 0;
  int     idle_cycles = 0;
  logic [31:0] key_pool[$];

  function automatic reply_t make_reply(logic [2:0] st, logic [31:0] id,
                                        int unsigned off, int unsigned cnt);
    reply_t r;
    r.status = st;
    r.result_id = id;
    r.offset = off[15:0];
    r.count = cnt[16:0];
    r.used_total = live_sum[16:0];
    r.dead_total = dead_sum[16:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_live[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic bit room_for(int unsigned len);
    return len > 0 && bump_edge + len <= CAPACITY;
  endfunction

  function automatic void put_at(int s, logic [31:0] key, int unsigned len);
    tbl_key[s] = key;
    tbl_live[s] = 1;
    tbl_off[s] = bump_edge[15:0];
    tbl_cnt[s] = len[16:0];
    tbl_dirty[s] = 1;
    bump_edge += len;
    live_sum += len;
  endfunction

  function automatic int unsigned release_slot(int s);
    int unsigned c;
    c = tbl_cnt[s];
    tbl_live[s] = 0;
    tbl_dirty[s] = 0;
    dead_sum += c;
    live_sum = (live_sum >= c) ? live_sum - c : 0;
    return c;
  endfunction

  // work out the replies for one accepted command
  task automatic predict_command(cmd_t c);
    reply_t rs[$];
    int s;
    int unsigned freed, pos;
    bit any_dirty;
    s = find_slot(c.entry_id);
    case (c.op)
      OP_ALLOC: begin
        if (s >= 0) rs.push_back(make_reply(STS_PRESENT, c.entry_id, 0, 0));
        else if (!room_for(c.length)) rs.push_back(make_reply(STS_NOSPACE, c.entry_id, 0, 0));
        else begin
          s = -1;
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_live[i] && s < 0) s = i;
          if (s < 0) rs.push_back(make_reply(STS_FULL, c.entry_id, 0, 0));
          else begin
            put_at(s, c.entry_id, c.length);
            rs.push_back(make_reply(STS_OK, c.entry_id, tbl_off[s], c.length));
          end
        end
      end
      OP_REALLOC: begin
        if (s < 0) rs.push_back(make_reply(STS_MISSING, c.entry_id, 0, 0));
        else begin
          freed = release_slot(s);
          if (!room_for(c.length))
            rs.push_back(make_reply(STS_NOSPACE, c.entry_id, 0, freed));
          else begin
            put_at(s, c.entry_id, c.length);
            rs.push_back(make_reply(STS_OK, c.entry_id, tbl_off[s], c.length));
          end
        end
      end
      OP_FREE: begin
        if (s < 0) rs.push_back(make_reply(STS_MISSING, c.entry_id, 0, 0));
        else begin
          freed = release_slot(s);
          rs.push_back(make_reply(STS_OK, c.entry_id, tbl_off[s], freed));
        end
      end
      OP_LOOKUP: begin
        if (s < 0) rs.push_back(make_reply(STS_MISSING, c.entry_id, 0, 0));
        else rs.push_back(make_reply(STS_OK, c.entry_id, tbl_off[s], tbl_cnt[s]));
      end
      OP_COMPACT: begin
        any_dirty = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_live[i] && tbl_dirty[i]) any_dirty = 1;
        if (any_dirty) rs.push_back(make_reply(STS_DIRTY, 0, 0, 0));
        else begin
          pos = 0;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_live[i]) begin
              tbl_off[i] = pos[15:0];
              pos += tbl_cnt[i];
            end
          bump_edge = pos;
          live_sum = pos;
          dead_sum = 0;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_live[i])
              rs.push_back(make_reply(STS_OK, tbl_key[i], tbl_off[i], tbl_cnt[i]));
        end
      end
      OP_LIST: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_live[i] && tbl_dirty[i])
            rs.push_back(make_reply(STS_OK, tbl_key[i], tbl_off[i], tbl_cnt[i]));
          tbl_dirty[i] = 0;
        end
      end
      default: ;
    endcase
    if (rs.size() == 0) rs.push_back(make_reply(STS_OK, 0, 0, 0));
    rs[rs.size() - 1].last = 1'b1;
    foreach (rs[i]) replies_due.push_back(rs[i]);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: present items from cmd_queue, change at falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_taken) begin
      // previous item (if any) was taken at the last rising edge
      if (cmd_queue.size() > 0 && !hold_send &&
          (quiet_mode || $urandom_range(99) >= 19)) begin
        in_tvalid <= 1;
        in_tdata <= {4'b0, cmd_queue.pop_front()};
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= quiet_mode || $urandom_range(99) >= 19;
  end

  // monitor: sample at rising edge
  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_tvalid && in_tready) begin
        predict_command(cmd_t'(in_tdata[51:0]));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[101:0], out_tlast};
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            $display("%0t:  status %0d/%0d id %h/%h off %0d/%0d cnt %0d/%0d",
                     $time, want.status, got.status, want.result_id, got.result_id,
                     want.offset, got.offset, want.count, got.count);
            $display("%0t:  used %0d/%0d dead %0d/%0d last %0d/%0d", $time,
                     want.used_total, got.used_total, want.dead_total, got.dead_total,
                     want.last, got.last);
            errors++;
          end
        end
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(9) < 8)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [16:0] pick_len();
    case ($urandom_range(19))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65536, 0));
      3: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(2000, 1));
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [31:0] id, logic [16:0] len);
    cmd_t c;
    c.op = op;
    c.entry_id = id;
    c.length = len;
    cmd_queue.push_back(c);
    if (key_pool.size() < 40) key_pool.push_back(id);
  endfunction

  function automatic void queue_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 35) queue_cmd(OP_ALLOC, pick_key(), pick_len());
      else if (k < 47) queue_cmd(OP_REALLOC, pick_key(), pick_len());
      else if (k < 65) queue_cmd(OP_FREE, pick_key(), 17'($urandom));
      else if (k < 78) queue_cmd(OP_LOOKUP, pick_key(), 17'($urandom));
      else if (k < 87) queue_cmd(OP_LIST, $urandom, 17'($urandom));
      else if (k < 95) queue_cmd(OP_COMPACT, $urandom, 17'($urandom));
      else queue_cmd(3'($urandom_range(7, 6)), $urandom, 17'($urandom));
    end
  endfunction

  task automatic drain();
    while (cmd_queue.size() > 0 || in_tvalid || replies_due.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_live[i] = 0;
      tbl_dirty[i] = 0;
    end
    bump_edge = 0;
    live_sum = 0;
    dead_sum = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every op, empty lists, unused codes
    queue_cmd(OP_COMPACT, 0, 0);
    queue_cmd(OP_LIST, 0, 0);
    queue_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 0);
    queue_cmd(OP_ALLOC, 32'h0, 0);
    queue_cmd(OP_ALLOC, 32'hFFFF_FFFF, 17'd65537);
    queue_cmd(OP_ALLOC, 32'hFFFF_FFFF, 17'd65536);
    queue_cmd(OP_ALLOC, 32'h1, 17'd1);
    queue_cmd(OP_ALLOC, 32'hFFFF_FFFF, 17'd5);
    queue_cmd(OP_COMPACT, 0, 0);
    queue_cmd(OP_LIST, 0, 0);
    queue_cmd(OP_FREE, 32'hFFFF_FFFF, 17'h1FFFF);
    queue_cmd(OP_ALLOC, 32'hA5A5_5A5A, 17'd300);
    queue_cmd(OP_ALLOC, 32'h0, 17'd100);
    queue_cmd(OP_REALLOC, 32'hA5A5_5A5A, 17'd400);
    queue_cmd(OP_REALLOC, 32'h0, 17'd131071);
    queue_cmd(OP_REALLOC, 32'h1234_5678, 17'd4);
    queue_cmd(OP_FREE, 32'h1234_5678, 0);
    queue_cmd(OP_LOOKUP, 32'hA5A5_5A5A, 0);
    queue_cmd(OP_LIST, 0, 0);
    queue_cmd(OP_COMPACT, 0, 0);
    queue_cmd(OP_LOOKUP, 32'hA5A5_5A5A, 0);
    queue_cmd(3'd6, 32'hFFFF_FFFF, 17'h1FFFF);
    queue_cmd(3'd7, 0, 0);
    drain();

    // fill the table to overflow, then a full-table list, a free and a compact
    hold_send = 1;
    for (int i = 0; i < 66; i++) queue_cmd(OP_ALLOC, 32'h100 + i, 17'd7);
    queue_cmd(OP_LIST, 0, 0);
    queue_cmd(OP_FREE, 32'h105, 0);
    queue_cmd(OP_COMPACT, 0, 0);
    hold_send = 0;
    drain();
    // clear out the filled table
    for (int i = 0; i < 66; i++) queue_cmd(OP_FREE, 32'h100 + i, 0);
    queue_cmd(OP_COMPACT, 0, 0);
    drain();

    key_pool.delete();
    queue_random(60);
    drain();
    // pause until every result is in, then a run with no idling
    quiet_mode = 1;
    queue_random(70);
    drain();
    quiet_mode = 0;
    queue_random(70);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
